// ===== src/fmps_pkg.sv =====
// ----------------------------------------------------------------------------
// fmps_pkg
// Shared types and constants for the footswitch MIDI preset stepper.
// ----------------------------------------------------------------------------
package fmps_pkg;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [7:0]  STATUS_CC      = 8'hB0;
  localparam logic [7:0]  CTRL_UP        = 8'h82;
  localparam logic [7:0]  CTRL_DOWN      = 8'h80;
  localparam logic [7:0]  COUNT_RESET    = 8'd8;
  localparam logic [31:0] DEBOUNCE_RESET = 32'd100;
  localparam logic [7:0]  MAX_RESET      = 8'hFE;
  localparam logic [3:0]  CHANNEL_RESET  = 4'd0;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_CHANNEL        = 2'd0,
    REG_DEBOUNCE_TICKS = 2'd1,
    REG_PRESET_MAX     = 2'd2
  } reg_idx_t;

  // Position of the byte being sent within one control change message.
  typedef enum logic [1:0] {
    BYTE_STATUS = 2'd0,
    BYTE_CTRL   = 2'd1,
    BYTE_COUNT  = 2'd2
  } byte_sel_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [31:0] debounce_ticks;
    logic [7:0]  preset_max;
  } cfg_t;

endpackage

// ===== src/fmps_if.sv =====
// ----------------------------------------------------------------------------
// fmps_press_if / fmps_midi_if
// Valid/ready channels for footswitch presses and MIDI message bytes.
// ----------------------------------------------------------------------------
interface fmps_press_if;
  logic        valid;
  logic        ready;
  logic        switch_up;
  logic [31:0] timestamp;

  modport source (output valid, output switch_up, output timestamp, input ready);
  modport sink (input valid, input switch_up, input timestamp, output ready);
endinterface

interface fmps_midi_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic       last_byte;

  modport source (output valid, output midi_byte, output last_byte, input ready);
  modport sink (input valid, input midi_byte, input last_byte, output ready);
endinterface

// ===== src/fmps_apb_regs.sv =====
// ----------------------------------------------------------------------------
// fmps_apb_regs
// APB configuration registers: MIDI channel, debounce time and preset limit.
// ----------------------------------------------------------------------------
module fmps_apb_regs
  import fmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel        <= CHANNEL_RESET;
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.preset_max     <= MAX_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CHANNEL:        cfg.channel        <= pwdata[3:0];
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= pwdata[31:0];
        REG_PRESET_MAX:     cfg.preset_max     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHANNEL:        prdata = {28'd0, cfg.channel};
      REG_DEBOUNCE_TICKS: prdata = cfg.debounce_ticks;
      REG_PRESET_MAX:     prdata = {24'd0, cfg.preset_max};
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== src/footswitch_midi_preset_stepper.sv =====
// ----------------------------------------------------------------------------
// footswitch_midi_preset_stepper
// Debounces footswitch presses, steps a preset counter and sends MIDI CC bytes.
// ----------------------------------------------------------------------------
// Presses arrive on the press channel (switch_up, timestamp). A press counts
// only when the wrapped time since the same switch's previous press exceeds
// debounce_ticks; the previous time is updated either way. A counted down
// press decrements the preset counter (floor 0), an up press increments it
// (ceiling preset_max). Each counted press sends three bytes on the midi
// channel: status 0xB0 | channel, controller 0x82 (up) or 0x80 (down), and
// the new counter value with last_byte set.
// A press is taken into an input register and evaluated there; a counted
// press loads its message into the output register once the previous one
// is done. Bytes go out, status first, one per cycle while the receiver is
// ready; a rejected press sends nothing and leaves the input register
// without waiting for the output port. A new press is taken while the last
// byte of the previous message is being sent. When the receiver stalls,
// the byte holds and at most one more press waits in the input register.
// Reset sets the counter to 8, both previous times to 0, and the registers to
// channel 0, debounce 100 and maximum 254. pready is always high.
// ----------------------------------------------------------------------------
module footswitch_midi_preset_stepper
  import fmps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  fmps_press_if.sink            press,
  fmps_midi_if.source           midi,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  fmps_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic        in_valid;
  logic        in_up;
  logic [31:0] in_ts;

  // Preset counter and per-switch previous press times.
  logic [7:0]  preset_count;
  logic [7:0]  preset_count_next;
  logic [31:0] down_last_time;
  logic [31:0] up_last_time;

  // Output message register.
  logic        msg_valid;
  byte_sel_t   msg_idx;
  logic [7:0]  msg_status;
  logic        msg_up;
  logic [7:0]  msg_count;

  logic [31:0] prev_time;
  logic [31:0] elapsed;
  logic        pass;
  logic        msg_done;
  logic        msg_free;
  logic        advance;

  assign prev_time = in_up ? up_last_time : down_last_time;
  assign elapsed   = in_ts - prev_time;
  assign pass      = elapsed > cfg.debounce_ticks;

  assign msg_done = msg_valid & midi.ready & (msg_idx == BYTE_COUNT);
  assign msg_free = ~msg_valid | msg_done;
  assign advance  = in_valid & (~pass | msg_free);

  assign press.ready = ~in_valid | advance;

  always_comb begin
    preset_count_next = preset_count;
    if (in_up) begin
      if (preset_count < cfg.preset_max) begin
        preset_count_next = preset_count + 8'd1;
      end
    end else if (preset_count != 8'd0) begin
      preset_count_next = preset_count - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (press.ready) begin
      in_valid <= press.valid;
    end
    if (press.ready && press.valid) begin
      in_up <= press.switch_up;
      in_ts <= press.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_count   <= COUNT_RESET;
      down_last_time <= '0;
      up_last_time   <= '0;
    end else if (advance) begin
      if (in_up) begin
        up_last_time <= in_ts;
      end else begin
        down_last_time <= in_ts;
      end
      if (pass) begin
        preset_count <= preset_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
      msg_idx   <= BYTE_STATUS;
    end else if (advance && pass) begin
      msg_valid <= 1'b1;
      msg_idx   <= BYTE_STATUS;
    end else if (msg_done) begin
      msg_valid <= 1'b0;
      msg_idx   <= BYTE_STATUS;
    end else if (msg_valid && midi.ready) begin
      case (msg_idx)
        BYTE_STATUS: msg_idx <= BYTE_CTRL;
        BYTE_CTRL:   msg_idx <= BYTE_COUNT;
        default:     msg_idx <= BYTE_STATUS;
      endcase
    end
    if (advance && pass) begin
      msg_status <= STATUS_CC | {4'd0, cfg.channel};
      msg_up     <= in_up;
      msg_count  <= preset_count_next;
    end
  end

  assign midi.valid     = msg_valid;
  assign midi.last_byte = (msg_idx == BYTE_COUNT);

  always_comb begin
    case (msg_idx)
      BYTE_STATUS: midi.midi_byte = msg_status;
      BYTE_CTRL:   midi.midi_byte = msg_up ? CTRL_UP : CTRL_DOWN;
      BYTE_COUNT:  midi.midi_byte = msg_count;
      default:     midi.midi_byte = msg_count;
    endcase
  end

  // A counted press always starts a fresh message at its status byte.
  a_msg_start: assert property (@(posedge clk) disable iff (rst)
    advance && pass |=> msg_valid && msg_idx == BYTE_STATUS)
    else $error("counted press did not load a message");

  // A message that is still being sent is never overwritten.
  a_msg_hold: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_free |=> msg_valid && $stable(msg_count) && $stable(msg_up))
    else $error("pending message overwritten");

  // The counter only moves when a press leaves the input register.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(preset_count) && $stable(up_last_time) && $stable(down_last_time))
    else $error("state changed without a press");

  // After the final byte the next shown byte, if any, is a status byte.
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    msg_done |=> !msg_valid || msg_idx == BYTE_STATUS)
    else $error("message did not restart at status byte");

endmodule

// ===== sim/tb_footswitch_midi_preset_stepper.sv =====
// ----------------------------------------------------------------------------
// tb_footswitch_midi_preset_stepper
// Self-checking bench for the footswitch MIDI preset stepper.
// ----------------------------------------------------------------------------
// A short scripted sequence walks the debounce window edges, timer wrap,
// counter floor and ceiling, and a ceiling lowered under the count. Several
// register settings follow, each with random presses whose timestamps sit
// around the debounce window. A behavioral model of the counter predicts
// the MIDI bytes of all untyped presses, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_footswitch_midi_preset_stepper;
  import fmps_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam int NUM_PHASES    = 7;

  typedef enum logic {ROW_PRESS, ROW_WRITE} row_kind_t;

  // One scripted step: a press or a register write. Typed rows carry the
  // expected outcome directly; the others are checked against the model.
  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic        up;
    logic [31:0] value;
    logic        typed;
    logic        t_counted;
    logic [7:0]  t_count;
  } script_row_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       last_byte;
  } midi_beat_t;

  typedef struct packed {
    logic [31:0] channel;
    logic [31:0] debounce;
    logic [31:0] ceiling;
    int          n_items;
    logic        no_gaps;
    logic        long_hold;
    logic        pause_mid;
  } phase_t;

  localparam int NUM_ROWS = 27;

  script_row_t script [0:NUM_ROWS-1] = '{
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'd100,       1'b1, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'd201,       1'b1, 1'b1, 8'd9},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'd101,       1'b1, 1'b1, 8'd8},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd7},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_0020, 1'b1, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_0085, 1'b1, 1'b1, 8'd6},
    '{ROW_WRITE, REG_DEBOUNCE_TICKS, 1'b0, 32'd0,         1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_0085, 1'b1, 1'b0, 8'd0},
    '{ROW_WRITE, REG_CHANNEL,        1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_0086, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_0087, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_0088, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_0089, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_008A, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_008B, 1'b1, 1'b1, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_008C, 1'b1, 1'b1, 8'd0},
    '{ROW_WRITE, REG_PRESET_MAX,     1'b0, 32'd1,         1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'h0000_012C, 1'b1, 1'b1, 8'd1},
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'h0000_012D, 1'b1, 1'b1, 8'd1},
    '{ROW_WRITE, REG_PRESET_MAX,     1'b0, 32'd0,         1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'h0000_012E, 1'b1, 1'b1, 8'd1},
    '{ROW_PRESS, REG_CHANNEL,        1'b0, 32'h0000_008D, 1'b1, 1'b1, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'h0000_012F, 1'b1, 1'b1, 8'd0},
    '{ROW_WRITE, REG_DEBOUNCE_TICKS, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'h0000_0000, 1'b1, 1'b0, 8'd0},
    '{ROW_WRITE, REG_DEBOUNCE_TICKS, 1'b0, 32'hFFFF_FFFE, 1'b0, 1'b0, 8'd0},
    '{ROW_PRESS, REG_CHANNEL,        1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fmps_press_if press_ch();
  fmps_midi_if  midi_ch();

  footswitch_midi_preset_stepper u_top (
    .clk     (clk),
    .rst     (rst),
    .press   (press_ch),
    .midi    (midi_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state and register copies.
  logic [7:0]  model_count;
  logic [31:0] down_seen;
  logic [31:0] up_seen;
  logic [3:0]  cfg_channel;
  logic [31:0] cfg_debounce;
  logic [7:0]  cfg_ceiling;

  midi_beat_t pending_bytes[$];

  int  mismatches   = 0;
  int  n_presses    = 0;
  int  n_counted    = 0;
  int  n_bytes      = 0;
  int  n_writes     = 0;
  int  quiet_cycles = 0;
  bit  no_gaps      = 1'b0;
  bit  hold_req     = 1'b0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
  endtask

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  // Applies one press to the model and reports whether it counts.
  function automatic bit advance_preset(input logic up, input logic [31:0] stamp);
    logic [31:0] since;
    bit          counted;
    since   = stamp - (up ? up_seen : down_seen);
    counted = since > cfg_debounce;
    if (up) up_seen = stamp;
    else down_seen = stamp;
    if (counted) begin
      if (up) begin
        if (model_count < cfg_ceiling) model_count = model_count + 8'd1;
      end else if (model_count != 8'd0) begin
        model_count = model_count - 8'd1;
      end
    end
    return counted;
  endfunction

  function automatic void push_message(input logic up, input logic [7:0] count);
    pending_bytes.push_back('{STATUS_CC | {4'h0, cfg_channel}, 1'b0});
    pending_bytes.push_back('{up ? CTRL_UP : CTRL_DOWN, 1'b0});
    pending_bytes.push_back('{count, 1'b1});
  endfunction

  task automatic send_press(input logic up, input logic [31:0] stamp, input logic typed,
                            input logic t_counted, input logic [7:0] t_count);
    int gap;
    bit counted;
    gap = draw_gap();
    if (gap > 0) begin
      press_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    press_ch.valid     <= 1'b1;
    press_ch.switch_up <= up;
    press_ch.timestamp <= stamp;
    do @(posedge clk); while (!(press_ch.valid && press_ch.ready));
    n_presses++;
    counted = advance_preset(up, stamp);
    if (counted) n_counted++;
    if (typed) begin
      if (t_counted) push_message(up, t_count);
    end else if (counted) begin
      push_message(up, model_count);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Writes a register once the block is idle, then reads it back.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] masked;
    press_ch.valid <= 1'b0;
    wait_drained();
    // A rejected press may still be in flight with nothing expected from it.
    repeat (DRAIN_CYCLES) @(posedge clk);
    case (idx)
      REG_CHANNEL:        masked = {28'd0, value[3:0]};
      REG_DEBOUNCE_TICKS: masked = value;
      default:            masked = {24'd0, value[7:0]};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    n_writes++;
    case (idx)
      REG_CHANNEL:        cfg_channel  = value[3:0];
      REG_DEBOUNCE_TICKS: cfg_debounce = value;
      default:            cfg_ceiling  = value[7:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== masked) note_mismatch("register readback", masked, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold when asked.
  initial begin
    int idle;
    midi_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      idle = draw_gap();
      if (hold_req) begin
        idle     = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (idle > 0) begin
        midi_ch.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      midi_ch.ready <= 1'b1;
      do @(posedge clk); while (!(midi_ch.valid && midi_ch.ready));
    end
  end

  always @(posedge clk) begin
    midi_beat_t want;
    if (!rst && midi_ch.valid && midi_ch.ready) begin
      n_bytes++;
      if (pending_bytes.size() == 0) begin
        note_mismatch("unexpected byte", 32'd0, {24'd0, midi_ch.midi_byte});
      end else begin
        want = pending_bytes.pop_front();
        if (midi_ch.midi_byte !== want.midi_byte)
          note_mismatch("midi_byte", {24'd0, want.midi_byte}, {24'd0, midi_ch.midi_byte});
        if (midi_ch.last_byte !== want.last_byte)
          note_mismatch("last_byte", {31'd0, want.last_byte}, {31'd0, midi_ch.last_byte});
      end
    end
  end

  // Watchdog: a run in which nothing moves for too long is a failure.
  always @(posedge clk) begin
    if (rst || psel || (press_ch.valid && press_ch.ready) || (midi_ch.valid && midi_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a transfer.", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    phase_t      phases [NUM_PHASES];
    logic        up;
    logic [31:0] stamp;
    logic [31:0] last;
    int unsigned span;
    int          mode;

    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    press_ch.valid     <= 1'b0;
    press_ch.switch_up <= 1'b0;
    press_ch.timestamp <= '0;

    model_count  = COUNT_RESET;
    down_seen    = '0;
    up_seen      = '0;
    cfg_channel  = CHANNEL_RESET;
    cfg_debounce = DEBOUNCE_RESET;
    cfg_ceiling  = MAX_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (script[r].kind == ROW_WRITE)
        write_reg(script[r].idx, script[r].value);
      else
        send_press(script[r].up, script[r].value, script[r].typed,
                   script[r].t_counted, script[r].t_count);
    end

    phases[0] = '{32'd0, 32'd0, 32'd255, 50, 1'b0, 1'b0, 1'b0};
    phases[1] = '{32'd15, 32'($urandom_range(1, 50)), 32'($urandom_range(2, 12)),
                  50, 1'b0, 1'b1, 1'b0};
    phases[2] = '{32'($urandom_range(0, 15)), 32'hFFFF_FFFE, 32'd254, 40, 1'b0, 1'b0, 1'b0};
    phases[3] = '{$urandom, $urandom, $urandom, 50, 1'b0, 1'b0, 1'b0};
    phases[4] = '{32'($urandom_range(0, 15)), 32'd7, 32'd1, 50, 1'b1, 1'b0, 1'b0};
    phases[5] = '{32'($urandom_range(0, 15)), 32'd1000, 32'd0, 50, 1'b0, 1'b0, 1'b0};
    phases[6] = '{32'($urandom_range(0, 15)), 32'($urandom_range(0, 300)), 32'd254,
                  60, 1'b0, 1'b0, 1'b1};

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_CHANNEL, phases[p].channel);
      write_reg(REG_DEBOUNCE_TICKS, phases[p].debounce);
      write_reg(REG_PRESET_MAX, phases[p].ceiling);
      no_gaps = phases[p].no_gaps;
      for (int i = 0; i < phases[p].n_items; i++) begin
        if (phases[p].long_hold && i == 5) hold_req = 1'b1;
        if (phases[p].pause_mid && i == phases[p].n_items / 2) begin
          // Stop offering while the outstanding messages drain.
          press_ch.valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        up   = 1'($urandom_range(0, 1));
        last = up ? up_seen : down_seen;
        span = (cfg_debounce > 32'd2000) ? 4000 : 2 * cfg_debounce + 20;
        mode = $urandom_range(0, 9);
        // Most presses land near the debounce window so both outcomes occur.
        if (mode < 2)
          stamp = $urandom;
        else if (mode < 4)
          stamp = last + cfg_debounce + 32'($urandom_range(0, 3)) - 32'd1;
        else
          stamp = last + 32'($urandom_range(0, span));
        send_press(up, stamp, 1'b0, 1'b0, 8'd0);
      end
    end

    press_ch.valid <= 1'b0;
    no_gaps = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) note_mismatch("bytes never sent", pending_bytes.size(), 0);

    $display("Sent %0d presses (%0d counted), checked %0d MIDI bytes over %0d register writes.",
             n_presses, n_counted, n_bytes, n_writes);
    $display("Debounce from 0 to all ones, timer wrap, counter floor, ceiling and stalls covered.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fmps_pkg.sv
src/fmps_if.sv
src/fmps_apb_regs.sv
src/footswitch_midi_preset_stepper.sv
sim/tb_footswitch_midi_preset_stepper.sv
